// ===== rtl/core/sctf_pkg.sv =====
`default_nettype none
package sctf_pkg;

	localparam int ROW_W        = 10;
	localparam int COL_W        = 9;
	localparam int FRAME_W      = 6;
	localparam int BIT_W        = 6;
	localparam int CROW_W       = 4;
	localparam int CLBR_W       = 10;
	localparam int CLBC_W       = 8;
	localparam int WPF_W        = 7;
	localparam int MAJOR_W      = 9;
	localparam int WOFF_W       = 7;
	localparam int WIDX_W       = 10;
	localparam int BPOS_W       = 5;
	localparam int SKIP_W       = 64;
	localparam int SKIP_ENTRY_W = 8;
	localparam int CFG_IDX_W    = 3;

	localparam int SKIP_ENTRIES_DEF     = 8;
	localparam int FRAMES_IN_WINDOW_DEF = 4;

	// restoring divider: quotient bits retired per pipeline stage
	localparam int DIV_STEP   = 4;
	localparam int DIV_STAGES = (ROW_W + DIV_STEP - 1) / DIV_STEP;

	// rows per clock region = clb_rows * ceil(2^14 / clock_rows) >> 14, exact here
	localparam int RECIP_SHIFT = 14;
	localparam int RECIP_W     = 15;

	localparam logic [FRAME_W-1:0] FRAME_BASE_LO = FRAME_W'(26);
	localparam logic [FRAME_W-1:0] FRAME_BASE_HI = FRAME_W'(32);

	localparam logic [CROW_W-1:0]  CLOCK_ROWS_RST  = CROW_W'(3);
	localparam logic [CLBR_W-1:0]  CLB_ROWS_RST    = CLBR_W'(150);
	localparam logic [CLBC_W-1:0]  CLB_COLS_RST    = CLBC_W'(100);
	localparam logic [WPF_W-1:0]   WPF_RST         = WPF_W'(101);
	localparam logic [SKIP_W-1:0]  SKIP_COLUMNS_RST = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLOCK_ROWS   = 3'd0,
		REG_CLB_ROWS     = 3'd1,
		REG_CLB_COLS     = 3'd2,
		REG_WPF          = 3'd3,
		REG_FAMILY       = 3'd4,
		REG_SKIP_COLUMNS = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ROW   = 2'd1,
		ST_COL   = 2'd2,
		ST_FRAME = 2'd3
	} status_t;

	typedef struct packed {
		logic [CROW_W-1:0] clock_rows;
		logic [CLBR_W-1:0] clb_rows;
		logic [CLBC_W-1:0] clb_cols;
		logic [WPF_W-1:0]  words_per_frame;
		logic              family_select;
		logic [SKIP_W-1:0] skip_columns;
	} cfg_t;

	typedef struct packed {
		logic [ROW_W-1:0]   dividend;
		logic [ROW_W-1:0]   rows_per;
		logic [ROW_W-1:0]   rem;
		logic [ROW_W-1:0]   quo;
		status_t            status;
		logic [MAJOR_W-1:0] major;
		logic [FRAME_W-1:0] frame_off;
		logic               in_window;
		logic               base_hi;
		logic               bit_lo;
		logic [BPOS_W-1:0]  bit_pos;
	} item_t;

	function automatic logic [RECIP_W-1:0] recip(input logic [CROW_W-1:0] d);
		logic [RECIP_W-1:0] m;
		unique case (d)
			4'd1:    m = RECIP_W'(16384);
			4'd2:    m = RECIP_W'(8192);
			4'd3:    m = RECIP_W'(5462);
			4'd4:    m = RECIP_W'(4096);
			4'd5:    m = RECIP_W'(3277);
			4'd6:    m = RECIP_W'(2731);
			4'd7:    m = RECIP_W'(2341);
			4'd8:    m = RECIP_W'(2048);
			4'd9:    m = RECIP_W'(1821);
			4'd10:   m = RECIP_W'(1639);
			4'd11:   m = RECIP_W'(1490);
			4'd12:   m = RECIP_W'(1366);
			4'd13:   m = RECIP_W'(1261);
			4'd14:   m = RECIP_W'(1171);
			4'd15:   m = RECIP_W'(1093);
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sctf_front.sv =====
`default_nettype none
module sctf_front #(
	parameter int SKIP_ENTRIES     = sctf_pkg::SKIP_ENTRIES_DEF,
	parameter int FRAMES_IN_WINDOW = sctf_pkg::FRAMES_IN_WINDOW_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire sctf_pkg::cfg_t                cfg,
	input  wire logic                          up_valid,
	output logic                               up_stall,
	input  wire logic [sctf_pkg::ROW_W-1:0]    slice_y,
	input  wire logic [sctf_pkg::COL_W-1:0]    slice_x,
	input  wire logic [sctf_pkg::FRAME_W-1:0]  frame_index,
	input  wire logic [sctf_pkg::BIT_W-1:0]    bit_index,
	output logic                               dn_valid,
	output sctf_pkg::item_t                    dn_item,
	input  wire logic                          dn_stall
);

	localparam int CNT_W  = $clog2(SKIP_ENTRIES + 1);
	localparam int PROD_W = sctf_pkg::CLBR_W + sctf_pkg::RECIP_W;

	logic                                    valid_s1;
	sctf_pkg::item_t                         item_s1;
	sctf_pkg::item_t                         nxt;
	logic                                    adv;
	logic [PROD_W-1:0]                       prod;
	logic                                    rp_zero;
	logic [sctf_pkg::SKIP_ENTRY_W-1:0]       half;
	logic [CNT_W-1:0]                        cnt;
	logic                                    stop;
	logic [sctf_pkg::FRAME_W-1:0]            base;
	logic                                    row_bad;
	logic                                    col_bad;

	assign adv      = !valid_s1 || !dn_stall;
	assign up_stall = !adv;
	assign dn_valid = valid_s1;
	assign dn_item  = item_s1;

	always_comb begin
		prod    = PROD_W'(cfg.clb_rows) * PROD_W'(sctf_pkg::recip(cfg.clock_rows));
		rp_zero = (cfg.clock_rows == '0) ||
		          (cfg.clb_rows < sctf_pkg::CLBR_W'(cfg.clock_rows));

		half = slice_x[sctf_pkg::COL_W-1:1];
		cnt  = '0;
		stop = 1'b0;
		for (int j = 0; j < SKIP_ENTRIES; j++) begin
			if (!stop && half >= cfg.skip_columns[j*sctf_pkg::SKIP_ENTRY_W +: sctf_pkg::SKIP_ENTRY_W])
				cnt = cnt + CNT_W'(1);
			else
				stop = 1'b1;
		end

		base    = frame_index[sctf_pkg::FRAME_W-1] ? sctf_pkg::FRAME_BASE_HI
		                                           : sctf_pkg::FRAME_BASE_LO;
		row_bad = rp_zero || (slice_y >= cfg.clb_rows);
		col_bad = slice_x >= {cfg.clb_cols, 1'b0};

		nxt           = '0;
		nxt.dividend  = slice_y;
		nxt.rows_per  = rp_zero ? sctf_pkg::ROW_W'(1)
		                        : prod[sctf_pkg::RECIP_SHIFT +: sctf_pkg::ROW_W];
		nxt.major     = sctf_pkg::MAJOR_W'(half) + sctf_pkg::MAJOR_W'(cnt);
		nxt.frame_off = frame_index - base;
		nxt.in_window = (frame_index >= base) &&
		                (nxt.frame_off < sctf_pkg::FRAME_W'(FRAMES_IN_WINDOW));
		nxt.base_hi   = frame_index[sctf_pkg::FRAME_W-1];
		nxt.bit_lo    = !bit_index[sctf_pkg::BIT_W-1];
		nxt.bit_pos   = bit_index[sctf_pkg::BPOS_W-1:0];
		priority if (row_bad)
			nxt.status = sctf_pkg::ST_ROW;
		else if (col_bad)
			nxt.status = sctf_pkg::ST_COL;
		else if (!nxt.in_window)
			nxt.status = sctf_pkg::ST_FRAME;
		else
			nxt.status = sctf_pkg::ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (adv)
			valid_s1 <= up_valid;
	end

	always_ff @(posedge clk) begin
		if (adv && up_valid)
			item_s1 <= nxt;
	end

endmodule
`default_nettype wire

// ===== rtl/core/sctf_div_stage.sv =====
`default_nettype none
module sctf_div_stage #(
	parameter int STAGE = 0
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            up_valid,
	input  wire sctf_pkg::item_t up_item,
	output logic                 up_stall,
	output logic                 dn_valid,
	output sctf_pkg::item_t      dn_item,
	input  wire logic            dn_stall
);

	logic                          valid_sk;
	sctf_pkg::item_t               item_sk;
	sctf_pkg::item_t               nxt;
	logic                          adv;
	logic [sctf_pkg::ROW_W:0]      trial;
	logic                          qbit;

	assign adv      = !valid_sk || !dn_stall;
	assign up_stall = !adv;
	assign dn_valid = valid_sk;
	assign dn_item  = item_sk;

	// restoring division, dividend shifted out MSB first
	always_comb begin
		nxt   = up_item;
		trial = '0;
		qbit  = 1'b0;
		for (int i = 0; i < sctf_pkg::DIV_STEP; i++) begin
			if (STAGE * sctf_pkg::DIV_STEP + i < sctf_pkg::ROW_W) begin
				trial = {nxt.rem, nxt.dividend[sctf_pkg::ROW_W-1]};
				qbit  = trial >= {1'b0, nxt.rows_per};
				if (qbit)
					trial = trial - {1'b0, nxt.rows_per};
				nxt.rem      = trial[sctf_pkg::ROW_W-1:0];
				nxt.dividend = {nxt.dividend[sctf_pkg::ROW_W-2:0], 1'b0};
				nxt.quo      = {nxt.quo[sctf_pkg::ROW_W-2:0], qbit};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_sk <= 1'b0;
		else if (adv)
			valid_sk <= up_valid;
	end

	always_ff @(posedge clk) begin
		if (adv && up_valid)
			item_sk <= nxt;
	end

endmodule
`default_nettype wire

// ===== rtl/core/sctf_back.sv =====
`default_nettype none
module sctf_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire sctf_pkg::cfg_t                cfg,
	input  wire logic                          up_valid,
	input  wire sctf_pkg::item_t               up_item,
	output logic                               up_stall,
	output logic                               dn_valid,
	input  wire logic                          dn_stall,
	output logic                               bottom_half,
	output logic [sctf_pkg::CROW_W-1:0]        clock_region_row,
	output logic [sctf_pkg::MAJOR_W-1:0]       major_address,
	output logic [sctf_pkg::WOFF_W-1:0]        word_ofs,
	output logic [sctf_pkg::FRAME_W-1:0]       frame_base,
	output logic [sctf_pkg::WIDX_W-1:0]        word_index,
	output logic [sctf_pkg::BPOS_W-1:0]        bit_position,
	output logic [1:0]                         status
);

	localparam int GRP_W = sctf_pkg::ROW_W + 1;
	localparam int MUL_W = sctf_pkg::FRAME_W + sctf_pkg::WPF_W;

	logic                               valid_s5;
	logic                               bottom_s5;
	logic [sctf_pkg::CROW_W-1:0]        crow_s5;
	logic [sctf_pkg::MAJOR_W-1:0]       major_s5;
	logic [sctf_pkg::WOFF_W-1:0]        woff_s5;
	logic [sctf_pkg::FRAME_W-1:0]       base_s5;
	logic [sctf_pkg::WIDX_W-1:0]        widx_s5;
	logic [sctf_pkg::BPOS_W-1:0]        bpos_s5;
	sctf_pkg::status_t                  status_s5;

	logic                               adv;
	logic [GRP_W-1:0]                   group;
	logic [sctf_pkg::CROW_W-1:0]        mid;
	logic                               bottom;
	logic [sctf_pkg::CROW_W-1:0]        crow;
	logic [GRP_W-1:0]                   woff_full;
	logic [MUL_W-1:0]                   widx_full;
	logic [sctf_pkg::WIDX_W-1:0]        widx;

	assign adv      = !valid_s5 || !dn_stall;
	assign up_stall = !adv;
	assign dn_valid = valid_s5;

	always_comb begin
		group = GRP_W'(up_item.quo) + GRP_W'(1);
		mid   = (cfg.clock_rows >> 1) +
		        sctf_pkg::CROW_W'(cfg.clock_rows[0] ^ cfg.family_select);
		if (group > GRP_W'(mid)) begin
			bottom = 1'b0;
			crow   = sctf_pkg::CROW_W'(group - GRP_W'(mid) - GRP_W'(1));
		end else begin
			bottom = 1'b1;
			crow   = sctf_pkg::CROW_W'(GRP_W'(mid) - group);
		end

		if (up_item.rem >= (up_item.rows_per >> 1))
			woff_full = {up_item.rem, 1'b1};
		else
			woff_full = {up_item.rem, 1'b0};

		widx_full = MUL_W'(up_item.frame_off) * MUL_W'(cfg.words_per_frame) +
		            MUL_W'(woff_full) + MUL_W'(up_item.bit_lo);
		widx      = up_item.in_window ? widx_full[sctf_pkg::WIDX_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s5 <= 1'b0;
		else if (adv)
			valid_s5 <= up_valid;
	end

	always_ff @(posedge clk) begin
		if (adv && up_valid) begin
			bottom_s5 <= bottom;
			crow_s5   <= crow;
			major_s5  <= up_item.major;
			woff_s5   <= woff_full[sctf_pkg::WOFF_W-1:0];
			base_s5   <= up_item.base_hi ? sctf_pkg::FRAME_BASE_HI : sctf_pkg::FRAME_BASE_LO;
			widx_s5   <= widx;
			bpos_s5   <= up_item.bit_pos;
			status_s5 <= up_item.status;
		end
	end

	assign bottom_half      = bottom_s5;
	assign clock_region_row = crow_s5;
	assign major_address    = major_s5;
	assign word_ofs         = woff_s5;
	assign frame_base       = base_s5;
	assign word_index       = widx_s5;
	assign bit_position     = bpos_s5;
	assign status           = status_s5;

endmodule
`default_nettype wire

// ===== rtl/core/slice_to_config_frame_address_unit.sv =====
// Slice to configuration frame address unit.
// Input channel: in_valid / in_stall with slice_y, slice_x, frame_index
// and bit_index; one transaction per accepted edge (in_valid high, in_stall low).
// Output channel: out_valid / out_stall with the frame address fields and a
// status code; exactly one output transaction per input transaction, in order.
// Configuration: cfg_we writes cfg_data into register cfg_index at the clock
// edge; write only while no transaction is in flight.
// The path from input accept to out_valid is one front stage (range
// checks, rows-per-region reciprocal multiply, skip column scan), three
// restoring divider stages (four, four and two quotient bits) for the row
// split, and one back stage (midline, word offset, word index multiply) that
// is the output register. Throughput is one transaction per cycle unless the
// receiver stalls; then each stage holds its transaction and empty stages
// keep filling; in_stall rises only once every stage holds a transaction.
// Reset (arst_n low) empties the pipeline and loads the default device
// geometry into the configuration registers.
`default_nettype none
module slice_to_config_frame_address_unit #(
	parameter int SKIP_ENTRIES     = sctf_pkg::SKIP_ENTRIES_DEF,
	parameter int FRAMES_IN_WINDOW = sctf_pkg::FRAMES_IN_WINDOW_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [sctf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sctf_pkg::SKIP_W-1:0]     cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [sctf_pkg::ROW_W-1:0]      slice_y,
	input  wire logic [sctf_pkg::COL_W-1:0]      slice_x,
	input  wire logic [sctf_pkg::FRAME_W-1:0]    frame_index,
	input  wire logic [sctf_pkg::BIT_W-1:0]      bit_index,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 bottom_half,
	output logic [sctf_pkg::CROW_W-1:0]          clock_region_row,
	output logic [sctf_pkg::MAJOR_W-1:0]         major_address,
	output logic [sctf_pkg::WOFF_W-1:0]          word_ofs,
	output logic [sctf_pkg::FRAME_W-1:0]         frame_base,
	output logic [sctf_pkg::WIDX_W-1:0]          word_index,
	output logic [sctf_pkg::BPOS_W-1:0]          bit_position,
	output logic [1:0]                           status
);

	localparam int NS = sctf_pkg::DIV_STAGES;

	sctf_pkg::cfg_t   cfg_q;
	logic             div_valid [NS+1];
	sctf_pkg::item_t  div_item  [NS+1];
	logic             div_stall [NS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clock_rows      <= sctf_pkg::CLOCK_ROWS_RST;
			cfg_q.clb_rows        <= sctf_pkg::CLB_ROWS_RST;
			cfg_q.clb_cols        <= sctf_pkg::CLB_COLS_RST;
			cfg_q.words_per_frame <= sctf_pkg::WPF_RST;
			cfg_q.family_select   <= 1'b0;
			cfg_q.skip_columns    <= sctf_pkg::SKIP_COLUMNS_RST;
		end else if (cfg_we) begin
			unique case (sctf_pkg::cfg_reg_t'(cfg_index))
				sctf_pkg::REG_CLOCK_ROWS:   cfg_q.clock_rows      <= cfg_data[sctf_pkg::CROW_W-1:0];
				sctf_pkg::REG_CLB_ROWS:     cfg_q.clb_rows        <= cfg_data[sctf_pkg::CLBR_W-1:0];
				sctf_pkg::REG_CLB_COLS:     cfg_q.clb_cols        <= cfg_data[sctf_pkg::CLBC_W-1:0];
				sctf_pkg::REG_WPF:          cfg_q.words_per_frame <= cfg_data[sctf_pkg::WPF_W-1:0];
				sctf_pkg::REG_FAMILY:       cfg_q.family_select   <= cfg_data[0];
				sctf_pkg::REG_SKIP_COLUMNS: cfg_q.skip_columns    <= cfg_data;
				default: ;
			endcase
		end
	end

	sctf_front #(
		.SKIP_ENTRIES     (SKIP_ENTRIES),
		.FRAMES_IN_WINDOW (FRAMES_IN_WINDOW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.up_valid    (in_valid),
		.up_stall    (in_stall),
		.slice_y     (slice_y),
		.slice_x     (slice_x),
		.frame_index (frame_index),
		.bit_index   (bit_index),
		.dn_valid    (div_valid[0]),
		.dn_item     (div_item[0]),
		.dn_stall    (div_stall[0])
	);

	for (genvar k = 0; k < NS; k++) begin : g_div
		sctf_div_stage #(
			.STAGE (k)
		) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (div_valid[k]),
			.up_item  (div_item[k]),
			.up_stall (div_stall[k]),
			.dn_valid (div_valid[k+1]),
			.dn_item  (div_item[k+1]),
			.dn_stall (div_stall[k+1])
		);
	end

	sctf_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.up_valid         (div_valid[NS]),
		.up_item          (div_item[NS]),
		.up_stall         (div_stall[NS]),
		.dn_valid         (out_valid),
		.dn_stall         (out_stall),
		.bottom_half      (bottom_half),
		.clock_region_row (clock_region_row),
		.major_address    (major_address),
		.word_ofs         (word_ofs),
		.frame_base       (frame_base),
		.word_index       (word_index),
		.bit_position     (bit_position),
		.status           (status)
	);

`ifndef SYNTHESIS
	// backpressure reaches the input only through a blocked output
	a_stall_needs_blocked_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a blocked output");

	a_window_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == sctf_pkg::ST_FRAME) |-> (word_index == '0))
		else $error("word_index nonzero for frame outside window");

	a_major_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (major_address <= sctf_pkg::MAJOR_W'(255 + SKIP_ENTRIES)))
		else $error("major_address beyond skip table bound");
`endif

endmodule
`default_nettype wire

// ===== tb/slice_to_config_frame_address_unit_tb.sv =====
`timescale 1ns / 1ps

typedef struct packed {
	logic                          bottom_half;
	logic [sctf_pkg::CROW_W-1:0]   clock_region_row;
	logic [sctf_pkg::MAJOR_W-1:0]  major_address;
	logic [sctf_pkg::WOFF_W-1:0]   word_ofs;
	logic [sctf_pkg::FRAME_W-1:0]  frame_base;
	logic [sctf_pkg::WIDX_W-1:0]   word_index;
	logic [sctf_pkg::BPOS_W-1:0]   bit_position;
	sctf_pkg::status_t             status;
} frame_addr_t;

class frame_addr_scoreboard;
	localparam int SKIP_N = sctf_pkg::SKIP_ENTRIES_DEF;
	localparam int WINDOW = sctf_pkg::FRAMES_IN_WINDOW_DEF;

	logic [sctf_pkg::CROW_W-1:0] clock_rows;
	logic [sctf_pkg::CLBR_W-1:0] clb_rows;
	logic [sctf_pkg::CLBC_W-1:0] clb_cols;
	logic [sctf_pkg::WPF_W-1:0]  words_per_frame;
	logic                        family_select;
	logic [sctf_pkg::SKIP_W-1:0] skip_columns;

	frame_addr_t expected_addr_q[$];
	int checked;
	int errors;
	int status_seen[4];

	function new();
		clock_rows = sctf_pkg::CLOCK_ROWS_RST;
		clb_rows = sctf_pkg::CLB_ROWS_RST;
		clb_cols = sctf_pkg::CLB_COLS_RST;
		words_per_frame = sctf_pkg::WPF_RST;
		family_select = 1'b0;
		skip_columns = sctf_pkg::SKIP_COLUMNS_RST;
		checked = 0;
		errors = 0;
		foreach (status_seen[i]) status_seen[i] = 0;
	endfunction

	function void write_reg(sctf_pkg::cfg_reg_t idx, logic [sctf_pkg::SKIP_W-1:0] v);
		case (idx)
			sctf_pkg::REG_CLOCK_ROWS: clock_rows = v[sctf_pkg::CROW_W-1:0];
			sctf_pkg::REG_CLB_ROWS: clb_rows = v[sctf_pkg::CLBR_W-1:0];
			sctf_pkg::REG_CLB_COLS: clb_cols = v[sctf_pkg::CLBC_W-1:0];
			sctf_pkg::REG_WPF: words_per_frame = v[sctf_pkg::WPF_W-1:0];
			sctf_pkg::REG_FAMILY: family_select = v[0];
			sctf_pkg::REG_SKIP_COLUMNS: skip_columns = v;
			default: ;
		endcase
	endfunction

	function frame_addr_t translate(logic [sctf_pkg::ROW_W-1:0] row,
			logic [sctf_pkg::COL_W-1:0] col, logic [sctf_pkg::FRAME_W-1:0] frame,
			logic [sctf_pkg::BIT_W-1:0] bit_sel);
		frame_addr_t a;
		sctf_pkg::status_t st;
		int cr, rows_per, major, j, grp, mid, crow, rrow, woff, base, widx;
		st = sctf_pkg::ST_OK;
		cr = int'(clock_rows);
		rows_per = (cr != 0) ? int'(clb_rows) / cr : 0;
		if (rows_per == 0) begin
			st = sctf_pkg::ST_ROW;
			rows_per = 1;
		end else if (int'(row) >= int'(clb_rows)) begin
			st = sctf_pkg::ST_ROW;
		end else if (int'(col) >= 2 * int'(clb_cols)) begin
			st = sctf_pkg::ST_COL;
		end

		major = int'(col) / 2;
		for (j = 0; j < SKIP_N; j++)
			if (major < int'(skip_columns[8*j +: 8])) break;
		major += j;

		grp = int'(row) / rows_per + 1;
		if (family_select == 1'b0)
			mid = (cr % 2 == 0) ? cr / 2 : cr / 2 + 1;
		else
			mid = (cr % 2 == 0) ? cr / 2 + 1 : cr / 2;
		if (grp > mid) begin
			a.bottom_half = 1'b0;
			crow = grp - mid - 1;
		end else begin
			a.bottom_half = 1'b1;
			crow = mid - grp;
		end

		rrow = int'(row) % rows_per;
		woff = (rrow >= rows_per / 2) ? 2 * rrow + 1 : 2 * rrow;

		base = (int'(frame) < 32) ? int'(sctf_pkg::FRAME_BASE_LO)
			: int'(sctf_pkg::FRAME_BASE_HI);
		if (int'(frame) < base || int'(frame) - base >= WINDOW) begin
			if (st == sctf_pkg::ST_OK) st = sctf_pkg::ST_FRAME;
			widx = 0;
		end else begin
			widx = (int'(frame) - base) * int'(words_per_frame) + woff;
			if (bit_sel < 32) widx += 1;
		end

		a.clock_region_row = sctf_pkg::CROW_W'(crow);
		a.major_address = sctf_pkg::MAJOR_W'(major);
		a.word_ofs = sctf_pkg::WOFF_W'(woff);
		a.frame_base = sctf_pkg::FRAME_W'(base);
		a.word_index = sctf_pkg::WIDX_W'(widx);
		a.bit_position = bit_sel[sctf_pkg::BPOS_W-1:0];
		a.status = st;
		return a;
	endfunction

	function void note_input(logic [sctf_pkg::ROW_W-1:0] row,
			logic [sctf_pkg::COL_W-1:0] col, logic [sctf_pkg::FRAME_W-1:0] frame,
			logic [sctf_pkg::BIT_W-1:0] bit_sel);
		expected_addr_q.push_back(translate(row, col, frame, bit_sel));
	endfunction

	function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
		end
	endfunction

	function void check_result(frame_addr_t got);
		frame_addr_t want;
		if (expected_addr_q.size() == 0) begin
			errors++;
			$display("%0t: unexpected transaction, expected none, actual %p", $time, got);
			return;
		end
		want = expected_addr_q.pop_front();
		checked++;
		status_seen[want.status]++;
		compare_field("bottom_half", want.bottom_half, got.bottom_half);
		compare_field("clock_region_row", want.clock_region_row, got.clock_region_row);
		compare_field("major_address", want.major_address, got.major_address);
		compare_field("word_ofs", want.word_ofs, got.word_ofs);
		compare_field("frame_base", want.frame_base, got.frame_base);
		compare_field("word_index", want.word_index, got.word_index);
		compare_field("bit_position", want.bit_position, got.bit_position);
		compare_field("status", want.status, got.status);
	endfunction
endclass

module slice_to_config_frame_address_unit_tb;
	localparam int PIPE_LATENCY = 5;
	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_CYCLES = 80;
	localparam int N_PHASES = 9;
	localparam int PHASE_ITEMS = 120;
	localparam int PRESSURE_PHASE = 4;

	localparam logic [sctf_pkg::SKIP_W-1:0] SKIP_NONE = '1;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [sctf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [sctf_pkg::SKIP_W-1:0]     cfg_data = '0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	logic [sctf_pkg::ROW_W-1:0]      slice_y = '0;
	logic [sctf_pkg::COL_W-1:0]      slice_x = '0;
	logic [sctf_pkg::FRAME_W-1:0]    frame_index = '0;
	logic [sctf_pkg::BIT_W-1:0]      bit_index = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic                            bottom_half;
	logic [sctf_pkg::CROW_W-1:0]     clock_region_row;
	logic [sctf_pkg::MAJOR_W-1:0]    major_address;
	logic [sctf_pkg::WOFF_W-1:0]     word_ofs;
	logic [sctf_pkg::FRAME_W-1:0]    frame_base;
	logic [sctf_pkg::WIDX_W-1:0]     word_index;
	logic [sctf_pkg::BPOS_W-1:0]     bit_position;
	logic [1:0]                      status;

	frame_addr_scoreboard sb = new();

	int  gap_pct = 0;
	int  stall_pct = 0;
	bit  hold_req = 1'b0;
	int  input_held = 0;
	int  settings_used = 1;
	int  idle_cycles = 0;

	slice_to_config_frame_address_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.slice_y(slice_y),
		.slice_x(slice_x),
		.frame_index(frame_index),
		.bit_index(bit_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.bottom_half(bottom_half),
		.clock_region_row(clock_region_row),
		.major_address(major_address),
		.word_ofs(word_ofs),
		.frame_base(frame_base),
		.word_index(word_index),
		.bit_position(bit_position),
		.status(status)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_input(slice_y, slice_x, frame_index, bit_index);
			if (in_valid && in_stall)
				input_held++;
			if (out_valid && !out_stall)
				sb.check_result(frame_addr_t'({bottom_half, clock_region_row, major_address,
					word_ofs, frame_base, word_index, bit_position, status}));
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
		$display("** slice_to_config_frame_address_unit: FAILED **");
		$finish;
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		@(negedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (stall_pct > 0 && $urandom_range(1, 100) <= stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
				@(negedge clk);
			end
		end
	end

	task automatic send_item(input logic [sctf_pkg::ROW_W-1:0] row,
			input logic [sctf_pkg::COL_W-1:0] col,
			input logic [sctf_pkg::FRAME_W-1:0] frame,
			input logic [sctf_pkg::BIT_W-1:0] bit_sel);
		if (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
			repeat ($urandom_range(1, 12)) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		@(negedge clk);
		in_valid <= 1'b1;
		slice_y <= row;
		slice_x <= col;
		frame_index <= frame;
		bit_index <= bit_sel;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_random_item();
		logic [sctf_pkg::ROW_W-1:0]   row;
		logic [sctf_pkg::COL_W-1:0]   col;
		logic [sctf_pkg::FRAME_W-1:0] frame;
		if (sb.clb_rows != 0 && $urandom_range(1, 100) <= 80)
			row = sctf_pkg::ROW_W'($urandom_range(0, int'(sb.clb_rows) - 1));
		else
			row = sctf_pkg::ROW_W'($urandom);
		if (sb.clb_cols != 0 && $urandom_range(1, 100) <= 85)
			col = sctf_pkg::COL_W'($urandom_range(0, 2 * int'(sb.clb_cols) - 1));
		else
			col = sctf_pkg::COL_W'($urandom);
		if ($urandom_range(1, 100) <= 80)
			frame = ($urandom_range(0, 1) ? sctf_pkg::FRAME_BASE_HI : sctf_pkg::FRAME_BASE_LO)
				+ sctf_pkg::FRAME_W'($urandom_range(0, 3));
		else
			frame = sctf_pkg::FRAME_W'($urandom);
		send_item(row, col, frame, sctf_pkg::BIT_W'($urandom));
	endtask

	// wait until every translation has come back, then let the pipe empty
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.expected_addr_q.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(input sctf_pkg::cfg_reg_t idx,
			input logic [sctf_pkg::SKIP_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.write_reg(idx, val);
	endtask

	task automatic apply_config(input logic [sctf_pkg::SKIP_W-1:0] cr,
			input logic [sctf_pkg::SKIP_W-1:0] rows,
			input logic [sctf_pkg::SKIP_W-1:0] cols, input logic [sctf_pkg::SKIP_W-1:0] wpf,
			input logic [sctf_pkg::SKIP_W-1:0] fam, input logic [sctf_pkg::SKIP_W-1:0] skip);
		settle();
		write_reg(sctf_pkg::REG_CLOCK_ROWS, cr);
		write_reg(sctf_pkg::REG_CLB_ROWS, rows);
		write_reg(sctf_pkg::REG_CLB_COLS, cols);
		write_reg(sctf_pkg::REG_WPF, wpf);
		write_reg(sctf_pkg::REG_FAMILY, fam);
		write_reg(sctf_pkg::REG_SKIP_COLUMNS, skip);
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [sctf_pkg::SKIP_W-1:0] ascending_skip();
		int vals[$];
		int used;
		logic [sctf_pkg::SKIP_W-1:0] s;
		used = $urandom_range(0, 8);
		for (int j = 0; j < 8; j++)
			vals.push_back(j < used ? int'($urandom_range(0, 254)) : 255);
		vals.sort();
		for (int j = 0; j < 8; j++)
			s[8*j +: 8] = 8'(vals[j]);
		return s;
	endfunction

	function automatic logic [sctf_pkg::SKIP_W-1:0] wide_random();
		return {$urandom, $urandom};
	endfunction

	task automatic pick_config(input int kind);
		int cr;
		case (kind)
			0: apply_config(15, 1023, 255, 127, 1, ascending_skip());
			1: apply_config(1, 1, 1, 1, 0, SKIP_NONE);
			2: begin
				cr = $urandom_range(1, 15);
				apply_config(sctf_pkg::SKIP_W'(cr),
					sctf_pkg::SKIP_W'($urandom_range(cr, 1023)),
					sctf_pkg::SKIP_W'($urandom_range(1, 255)),
					sctf_pkg::SKIP_W'($urandom_range(1, 127)),
					sctf_pkg::SKIP_W'($urandom_range(0, 1)), ascending_skip());
			end
			default: apply_config(wide_random(), wide_random(), wide_random(),
				wide_random(), wide_random(), wide_random());
		endcase
	endtask

	initial begin
		int kinds[N_PHASES];
		kinds = '{2, 0, 1, 3, 2, 2, 3, 0, 2};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset geometry: field extremes, half/region boundaries, every status
		send_item(0, 0, 26, 0);
		send_item(149, 199, 29, 63);
		send_item(150, 0, 26, 31);
		send_item(1023, 511, 63, 63);
		send_item(10, 200, 30, 5);
		send_item(10, 5, 25, 32);
		send_item(24, 6, 31, 1);
		send_item(25, 7, 32, 33);
		send_item(49, 8, 35, 0);
		send_item(50, 9, 36, 62);
		send_item(99, 198, 0, 15);
		send_item(100, 1, 27, 47);
		send_item(682, 341, 42, 21);
		send_item(341, 170, 21, 42);
		// no clock rows at all
		apply_config(0, 150, 100, 101, 0, SKIP_NONE);
		send_item(5, 3, 28, 40);
		send_item(0, 0, 33, 7);
		// fewer CLB rows than clock rows
		apply_config(15, 10, 100, 101, 1, SKIP_NONE);
		send_item(9, 4, 26, 63);
		send_item(3, 199, 34, 0);
		// full skip table
		apply_config(4, 160, 255, 127, 1, '0);
		send_item(0, 511, 26, 0);
		send_item(159, 0, 33, 32);
		// skip table out of order
		apply_config(2, 64, 255, 50, 0, 64'hFF20_FF80_1030_4005);
		send_item(40, 20, 29, 31);
		send_item(63, 300, 35, 32);
		send_item(32, 509, 32, 60);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			pick_config(kinds[ph]);
			if (ph == N_PHASES - 1) begin
				gap_pct = 0;
				stall_pct = 0;
			end else if (ph == PRESSURE_PHASE) begin
				gap_pct = 0;
				stall_pct = 20;
				hold_req = 1'b1;
			end else begin
				gap_pct = (ph % 3) * 15;
				stall_pct = ((ph + 1) % 3) * 20;
			end
			repeat (PHASE_ITEMS) send_random_item();
		end

		settle();
		$display("checked %0d translations over %0d register settings", sb.checked,
			settings_used);
		$display("status ok/row/col/frame: %0d/%0d/%0d/%0d, input held off %0d cycles",
			sb.status_seen[sctf_pkg::ST_OK], sb.status_seen[sctf_pkg::ST_ROW],
			sb.status_seen[sctf_pkg::ST_COL], sb.status_seen[sctf_pkg::ST_FRAME],
			input_held);
		if (sb.errors == 0 && sb.expected_addr_q.size() == 0) begin
			$display("** slice_to_config_frame_address_unit: PASSED **");
		end else begin
			$display("** slice_to_config_frame_address_unit: FAILED **");
		end
		$finish;
	end
endmodule
